@@ src/pli_pkg.sv @@
// Shared types and constants for the piecewise linear interpolator.
// Holds the controller/datapath command and status structs and the read address codes.
// No dependencies.
package pli_pkg;

    localparam int MAX_POINTS = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int XY_W       = 32;
    localparam int RAM_W      = 2 * XY_W;
    localparam int DIV_STEPS  = XY_W + 1;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    // Read address selection for the breakpoint RAM.
    localparam logic [1:0] AS_ZERO     = 2'd0;
    localparam logic [1:0] AS_NEXT     = 2'd1;
    localparam logic [1:0] AS_SEG      = 2'd2;
    localparam logic [1:0] AS_SEG_NEXT = 2'd3;

    // Status codes of a result word.
    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_BELOW  = 2'd1;
    localparam logic [1:0] ST_ABOVE  = 2'd2;

    typedef struct packed {
        logic       load_wr;
        logic       start;
        logic       scan;
        logic [1:0] addr_sel;
        logic       cap_l;
        logic       cap_r;
        logic       diff;
        logic       mul;
        logic       add;
        logic       chk;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_needed;
    } sts_t;

endpackage

@@ src/pli_ram.sv @@
// Generic simple dual-port RAM with registered read data.
// One write port and one read port; no dependencies.
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/pli_ctrl.sv @@
// Sequencing state machine of the piecewise linear interpolator.
// Depends on pli_pkg for the command and status structs.
module pli_ctrl
    import pli_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic action,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_RD_L  = 4'd2;
    localparam logic [3:0] S_RD_R  = 4'd3;
    localparam logic [3:0] S_CAP_R = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_ADD   = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '0;
        cmd.addr_sel = AS_NEXT;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.addr_sel = AS_ZERO;
                if (accept)
                begin
                    if (action)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_RD_L;
                end
            end
            S_RD_L:
            begin
                cmd.addr_sel = AS_SEG;
                state_next   = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.addr_sel = AS_SEG_NEXT;
                cmd.cap_l    = 1'b1;
                state_next   = S_CAP_R;
            end
            S_CAP_R:
            begin
                cmd.cap_r  = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.chk = 1'b1;
                if (sts.div_needed)
                begin
                    dcnt_next  = DCNT_W'(DIV_STEPS - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/pli_dp.sv @@
// Datapath of the piecewise linear interpolator: breakpoint RAM, segment search,
// split multiplier, restoring divider, rounding and saturation, output word register.
// Depends on pli_pkg and pli_ram.
module pli_dp
    import pli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               cfg_valid,
    input  logic [CNT_W-1:0]   cfg_data,
    input  logic [ADDR_W-1:0]  point_index,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] query_x,
    output logic signed [31:0] result_y,
    output logic [1:0]         status,
    output logic               saturated
);

    localparam logic [1:0] MODE_DIV  = 2'd0;
    localparam logic [1:0] MODE_ZERO = 2'd1;
    localparam logic [1:0] MODE_SAT  = 2'd2;

    localparam logic signed [34:0] RES_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] RES_MIN = -35'sh0_8000_0000;

    logic [CNT_W-1:0]   pcount_reg;
    logic [CNT_W-1:0]   n_reg;
    logic signed [31:0] q_reg;
    logic [ADDR_W-1:0]  tag_reg;
    logic [ADDR_W-1:0]  seg_reg;
    logic               below_reg, above_reg;
    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [32:0]        a_reg, b_reg, d_reg;
    logic               neg_reg, zero_w_reg;
    logic [63:0]        plo_reg;
    logic [65:0]        prod_reg;
    logic [32:0]        rem_reg, dvd_reg;
    logic [1:0]         mode_reg;
    logic signed [31:0] res_reg;
    logic [1:0]         status_reg;
    logic               sat_reg;

    logic [ADDR_W-1:0]  raddr;
    logic [RAM_W-1:0]   rdata;
    logic signed [31:0] rd_x;
    logic [CNT_W-1:0]   nm1, nm2;
    logic [ADDR_W-1:0]  seg_idx;

    logic signed [32:0] dx, dy, w;
    logic [33:0]        div_try;
    logic               div_bit;
    logic [33:0]        m;
    logic signed [34:0] sum;
    logic signed [31:0] res_next;
    logic               sat_next;
    logic [1:0]         status_next;

    pli_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.load_wr),
        .waddr (point_index),
        .wdata ({point_x, point_y}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_x = $signed(rdata[RAM_W-1:XY_W]);
    assign nm1  = n_reg - CNT_W'(1);
    assign nm2  = n_reg - CNT_W'(2);

    // Below takes precedence over above, as for a table whose ends cross.
    always_comb
    begin
        if (below_reg)
        begin
            seg_idx = '0;
        end
        else if (above_reg)
        begin
            seg_idx = nm2[ADDR_W-1:0];
        end
        else
        begin
            seg_idx = seg_reg;
        end
    end

    always_comb
    begin
        unique case (cmd.addr_sel)
            AS_ZERO:     raddr = '0;
            AS_NEXT:     raddr = tag_reg + ADDR_W'(1);
            AS_SEG:      raddr = seg_idx;
            AS_SEG_NEXT: raddr = seg_idx + ADDR_W'(1);
            default:     raddr = '0;
        endcase
    end

    always_comb
    begin
        sts.scan_last  = ({1'b0, tag_reg} == nm1);
        sts.div_needed = !zero_w_reg && (prod_reg[65:33] < d_reg);
    end

    assign dx = 33'(q_reg) - 33'(x1_reg);
    assign dy = 33'(y2_reg) - 33'(y1_reg);
    assign w  = 33'(x2_reg) - 33'(x1_reg);

    assign div_try = {rem_reg, dvd_reg[32]};
    assign div_bit = (div_try >= {1'b0, d_reg});

    // Quotient rounded half up on the magnitude, then the signed sum is clipped.
    always_comb
    begin
        m = {1'b0, dvd_reg} + 34'(({rem_reg, 1'b0} >= {1'b0, d_reg}));
        if (neg_reg)
        begin
            sum = 35'(y1_reg) - $signed({1'b0, m});
        end
        else
        begin
            sum = 35'(y1_reg) + $signed({1'b0, m});
        end
        sat_next = 1'b0;
        res_next = sum[31:0];
        case (mode_reg)
            MODE_ZERO:
            begin
                res_next = y1_reg;
            end
            MODE_SAT:
            begin
                sat_next = 1'b1;
                res_next = neg_reg ? RES_MIN[31:0] : RES_MAX[31:0];
            end
            default:
            begin
                if (sum > RES_MAX)
                begin
                    sat_next = 1'b1;
                    res_next = RES_MAX[31:0];
                end
                else if (sum < RES_MIN)
                begin
                    sat_next = 1'b1;
                    res_next = RES_MIN[31:0];
                end
            end
        endcase
        if (below_reg)
        begin
            status_next = ST_BELOW;
        end
        else if (above_reg)
        begin
            status_next = ST_ABOVE;
        end
        else
        begin
            status_next = ST_INSIDE;
        end
    end

    function automatic logic [CNT_W-1:0] pc_clamped_n(input logic [CNT_W-1:0] pc);
        logic [CNT_W-1:0] r;
        if (pc < CNT_W'(2))
        begin
            r = CNT_W'(2);
        end
        else if (pc > CNT_W'(MAX_POINTS))
        begin
            r = CNT_W'(MAX_POINTS);
        end
        else
        begin
            r = pc;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= CNT_W'(2);
        end
        else if (cfg_valid)
        begin
            pcount_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_reg     <= query_x;
            n_reg     <= pc_clamped_n(pcount_reg);
            tag_reg   <= '0;
            seg_reg   <= '0;
            below_reg <= 1'b0;
            above_reg <= 1'b0;
        end
        if (cmd.scan)
        begin
            tag_reg <= tag_reg + ADDR_W'(1);
            if (tag_reg == '0)
            begin
                below_reg <= (q_reg < rd_x);
            end
            else if (({1'b0, tag_reg} < nm1) && (rd_x <= q_reg))
            begin
                seg_reg <= tag_reg;
            end
            if ({1'b0, tag_reg} == nm1)
            begin
                above_reg <= (q_reg > rd_x);
            end
        end
        if (cmd.cap_l)
        begin
            x1_reg <= $signed(rdata[RAM_W-1:XY_W]);
            y1_reg <= $signed(rdata[XY_W-1:0]);
        end
        if (cmd.cap_r)
        begin
            x2_reg <= $signed(rdata[RAM_W-1:XY_W]);
            y2_reg <= $signed(rdata[XY_W-1:0]);
        end
        if (cmd.diff)
        begin
            a_reg      <= dx[32] ? 33'(-dx) : dx;
            b_reg      <= dy[32] ? 33'(-dy) : dy;
            d_reg      <= w[32] ? 33'(-w) : w;
            neg_reg    <= dx[32] ^ dy[32] ^ w[32];
            zero_w_reg <= (w == '0);
        end
        if (cmd.mul)
        begin
            plo_reg <= a_reg[31:0] * b_reg[31:0];
        end
        // The 33rd bits of the magnitudes add shifted cross terms to the low product.
        if (cmd.add)
        begin
            prod_reg <= 66'(plo_reg)
                      + (a_reg[32] ? {2'b00, b_reg[31:0], 32'd0} : 66'd0)
                      + (b_reg[32] ? {2'b00, a_reg[31:0], 32'd0} : 66'd0)
                      + ((a_reg[32] && b_reg[32]) ? {2'b01, 64'd0} : 66'd0);
        end
        if (cmd.chk)
        begin
            rem_reg <= prod_reg[65:33];
            dvd_reg <= prod_reg[32:0];
            if (zero_w_reg)
            begin
                mode_reg <= MODE_ZERO;
            end
            else if (prod_reg[65:33] >= d_reg)
            begin
                mode_reg <= MODE_SAT;
            end
            else
            begin
                mode_reg <= MODE_DIV;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_bit ? 33'(div_try - {1'b0, d_reg}) : div_try[32:0];
            dvd_reg <= {dvd_reg[31:0], div_bit};
        end
        if (cmd.out_load)
        begin
            res_reg    <= res_next;
            status_reg <= status_next;
            sat_reg    <= sat_next;
        end
    end

    assign result_y  = res_reg;
    assign status    = status_reg;
    assign saturated = sat_reg;

endmodule

@@ src/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator over a table of up to 16 signed Q16.16 breakpoints.
// An evaluate word runs a serial scan of n table entries (n = breakpoints in use) and a
// 33-step restoring divider. A zero-width segment or a quotient sure to saturate skips
// the divider. The result waits while the previous result word is still stalled; the
// next word can be taken in the cycle after the result is loaded.
// Reset (rst_n, asynchronous, active low) clears the controller and sets point_count to 2;
// the breakpoint RAM is not cleared and holds nothing defined until loaded.
module piecewise_linear_interpolator
    import pli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Input channel: one word is either a breakpoint load or an evaluate request.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [3:0]         point_index,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] query_x,
    // Result channel: one word for each evaluate request.
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_y,
    output logic [1:0]         status,
    output logic               saturated,
    // Configuration channel: writes the point_count register.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // The register is a plain flop, so a configuration write is always taken at once.
    assign cfg_ready = 1'b1;

    // The controller walks the scan, the segment fetch, the multiply, the divide and the
    // final rounding; the result word sits in an output register so that the input side is
    // free again while it waits to be taken.
    pli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the breakpoint RAM and all arithmetic; a write on the
    // configuration channel goes straight to its point_count register.
    pli_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .query_x     (query_x),
        .result_y    (result_y),
        .status      (status),
        .saturated   (saturated)
    );

endmodule

@@ bench/tb_piecewise_linear_interpolator.sv @@
// Self-checking testbench for the piecewise linear interpolator: a curve model class
// predicts every result word, and plain tasks drive the breakpoint and evaluate words.
// Depends on pli_pkg and the piecewise_linear_interpolator RTL; reads no files.
module tb_piecewise_linear_interpolator
    import pli_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Meaning of the action field of an input word.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    // Limits of a signed Q16.16 result, held wide so that sums can be compared.
    localparam longint Y_MAX = 64'sd2147483647;
    localparam longint Y_MIN = -64'sd2147483648;

    // Random part of the run stops once this many input words have gone in.
    localparam int TOTAL_WORDS = 1420;

    // Cycles to let pass after the last result before a register write or the end.
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        logic signed [31:0] y;
        logic [1:0]         st;
        logic               sat;
    } interp_result_t;

    // The curve model keeps its own copy of the breakpoint table and the point count,
    // works out the result of each evaluate word as it is accepted, and matches the
    // result words against those predictions in order.
    class pli_curve;
        logic signed [31:0] x_pts [MAX_POINTS];
        logic signed [31:0] y_pts [MAX_POINTS];
        logic [4:0]         point_count;
        interp_result_t     awaited [$];
        int                 errors;

        function new();
            foreach (x_pts[i])
            begin
                x_pts[i] = '0;
                y_pts[i] = '0;
            end
            point_count = 5'd2;
            errors      = 0;
        endfunction

        function interp_result_t interpolate(logic signed [31:0] qx);
            interp_result_t r;
            int             n;
            int             seg;
            longint         q, x1, x2, y1, y2, w, dx, dy, m, res;
            logic [71:0]    mag_dx, mag_dy, mag_w, prod, quo, rem;
            bit             neg;

            // Counts outside the table size are pulled to the nearest legal value.
            n = (point_count < 2) ? 2 : (point_count > MAX_POINTS) ? MAX_POINTS : point_count;

            if (qx < x_pts[0])
            begin
                seg  = 0;
                r.st = ST_BELOW;
            end
            else if (qx > x_pts[n - 1])
            begin
                seg  = n - 2;
                r.st = ST_ABOVE;
            end
            else
            begin
                // Last segment whose left end lies at or below the query; a query on
                // the last point therefore lands on the last segment.
                seg  = 0;
                r.st = ST_INSIDE;
                for (int k = 1; k < n - 1; k++)
                    if (x_pts[k] <= qx)
                        seg = k;
            end

            q     = qx;
            x1    = x_pts[seg];
            x2    = x_pts[seg + 1];
            y1    = y_pts[seg];
            y2    = y_pts[seg + 1];
            w     = x2 - x1;
            r.sat = 1'b0;

            if (w == 0)
                res = y1;
            else
            begin
                dx     = q - x1;
                dy     = y2 - y1;
                neg    = ((dx < 0) != (dy < 0)) != (w < 0);
                mag_dx = (dx < 0) ? -dx : dx;
                mag_dy = (dy < 0) ? -dy : dy;
                mag_w  = (w < 0) ? -w : w;
                prod   = mag_dx * mag_dy;
                if (prod == 0)
                    m = 0;
                else
                begin
                    quo = prod / mag_w;
                    rem = prod % mag_w;
                    // The quotient is capped before rounding; half a step rounds
                    // away from zero since the sign is applied afterwards.
                    if (quo > (72'd1 << 40))
                        m = longint'(1) << 40;
                    else
                    begin
                        m = longint'(quo[63:0]);
                        if (rem * 2 >= mag_w)
                            m++;
                    end
                end
                res = neg ? y1 - m : y1 + m;
                if (res > Y_MAX)
                begin
                    res   = Y_MAX;
                    r.sat = 1'b1;
                end
                else if (res < Y_MIN)
                begin
                    res   = Y_MIN;
                    r.sat = 1'b1;
                end
            end

            r.y = res[31:0];
            return r;
        endfunction

        function void take_word(logic act, logic [3:0] idx, logic signed [31:0] px,
                                logic signed [31:0] py, logic signed [31:0] qx);
            if (act == ACT_LOAD)
            begin
                x_pts[idx] = px;
                y_pts[idx] = py;
            end
            else
                awaited.push_back(interpolate(qx));
        endfunction

        function void check_word(logic signed [31:0] y, logic [1:0] st, logic sat);
            interp_result_t want;

            if (awaited.size() == 0)
            begin
                $error("result word arrived with no evaluate outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (y !== want.y)
            begin
                $error("result_y expected %0d got %0d", want.y, y);
                errors++;
            end
            if (st !== want.st)
            begin
                $error("status expected %0d got %0d", want.st, st);
                errors++;
            end
            if (sat !== want.sat)
            begin
                $error("saturated expected %0d got %0d", want.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [3:0]         point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] query_x;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_y;
    logic [1:0]         status;
    logic               saturated;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [4:0]         cfg_data;

    pli_curve curve = new();

    // Slots loaded since reset; an evaluate is only sent when every slot in use
    // has been written, as unwritten slots hold nothing defined.
    logic [MAX_POINTS-1:0] loaded_slots;
    int                    words_sent;
    int                    burst_left;

    // Receiver pacing state, touched only by the stall generator.
    int stall_mode;
    int stall_hold;
    int stall_cycle;

    piecewise_linear_interpolator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .point_index (point_index),
        .point_x     (point_x),
        .point_y     (point_y),
        .query_x     (query_x),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_y    (result_y),
        .status      (status),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run, several times the slowest legal run with every
    // evaluate meeting the longest stalls and gaps.
    initial
    begin
        #10_000_000;
        $display("FAIL piecewise_linear_interpolator");
        $finish;
    end

    // Result words are taken at the edge where out_valid is high and out_stall low.
    // The DUT's outputs change only after the edge, so the values read here are
    // those that the edge itself saw.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            curve.check_word(result_y, status, saturated);
    end

    // The receiver switches between never stalling, stalling at random on single
    // cycles, and holding off in long stretches.
    always @(posedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 300 == 0)
            stall_mode = $urandom_range(0, 2);
        if (stall_hold > 0)
        begin
            stall_hold--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        stall_hold = $urandom_range(1, 20);
                        out_stall <= 1'b1;
                    end
                    else
                        out_stall <= 1'b0;
                end
            endcase
        end
    end

    // After each accepted word the sender either carries straight on within its
    // burst or drops valid for a gap and then starts a fresh burst.
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(20, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Presents one word and holds it until the block takes it.
    task automatic send_word(logic act, logic [3:0] idx, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] qx);
        in_valid    <= 1'b1;
        action      <= act;
        point_index <= idx;
        point_x     <= px;
        point_y     <= py;
        query_x     <= qx;
        do
            @(posedge clk);
        while (in_stall);
        curve.take_word(act, idx, px, py, qx);
        words_sent++;
        pace();
    endtask

    task automatic load_point(logic [3:0] idx, logic signed [31:0] px, logic signed [31:0] py);
        loaded_slots[idx] = 1'b1;
        send_word(ACT_LOAD, idx, px, py, $urandom());
    endtask

    // The unused fields of an evaluate word carry noise.
    task automatic evaluate(logic signed [31:0] qx);
        send_word(ACT_EVAL, 4'($urandom()), $urandom(), $urandom(), qx);
    endtask

    // The count register is only written with the block idle: all results in and
    // time enough for a trailing load to finish.
    task automatic write_count(logic [4:0] v);
        in_valid <= 1'b0;
        while (curve.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        curve.point_count = v;
    endtask

    function automatic int points_in_use(logic [4:0] v);
        return (v < 2) ? 2 : (v > MAX_POINTS) ? MAX_POINTS : int'(v);
    endfunction

    function automatic bit slots_ready(int n);
        for (int i = 0; i < n; i++)
            if (!loaded_slots[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Queries cluster on and around the breakpoints, inside segments, beyond both
    // ends of the table, and now and then anywhere in the 32-bit range.
    function automatic logic signed [31:0] pick_query(int n);
        int     k;
        longint q;
        longint lo;
        longint hi;
        longint xa;
        longint xb;

        k  = $urandom_range(0, n - 1);
        lo = curve.x_pts[0];
        hi = curve.x_pts[n - 1];
        xa = curve.x_pts[k];
        xb = (k < n - 1) ? longint'(curve.x_pts[k + 1]) : xa;
        case ($urandom_range(0, 7))
            0: q = xa;
            1: q = xa + 1;
            2: q = xa - 1;
            3: q = lo - longint'($urandom_range(1, 1 << $urandom_range(0, 30)));
            4: q = hi + longint'($urandom_range(1, 1 << $urandom_range(0, 30)));
            5: q = longint'($signed($urandom()));
            default: q = xa + (xb - xa) * longint'($urandom_range(0, 1024)) / 1024;
        endcase
        if (q > Y_MAX)
            q = Y_MAX;
        else if (q < Y_MIN)
            q = Y_MIN;
        return q[31:0];
    endfunction

    // Loads slots 0 to n-1 with ascending x. The step size is drawn per table so
    // that some tables are tightly packed and others span most of the range;
    // about one step in eight is zero, which gives segments of zero width.
    task automatic load_sorted_table(int n);
        longint             xv;
        longint             room;
        longint unsigned    r;
        int unsigned        step_max;
        int                 ymode;
        logic signed [31:0] yv;

        step_max = 1 << $urandom_range(0, 27);
        room     = 64'sd4294967295 - longint'(n - 1) * longint'(step_max);
        r        = {$urandom(), $urandom()};
        xv       = Y_MIN + longint'(r % longint'(room + 1));
        ymode    = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                xv += ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom_range(1, step_max));
            case (ymode)
                0: yv = $urandom();
                1: yv = $signed($urandom()) >>> $urandom_range(8, 24);
                default: yv = $signed($urandom()) >>> 4;
            endcase
            load_point(4'(i), xv[31:0], yv);
        end
    endtask

    initial
    begin
        int         phase;
        int         n;
        int         kind;
        logic [4:0] count_val;
        logic [4:0] fixed_counts [6];

        fixed_counts = '{5'd16, 5'd0, 5'd1, 5'd17, 5'd31, 5'd2};

        // Every input is known from time zero onwards.
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_LOAD;
        point_index  = '0;
        point_x      = '0;
        point_y      = '0;
        query_x      = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        loaded_slots = '0;
        words_sent   = 0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_hold   = 0;
        stall_cycle  = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words, run with the point count at its reset value of two.
        // A plain ramp from (0,0) to (1.0,2.0): mid-segment, both end points,
        // and one query beyond each end.
        load_point(4'd0, 32'sh0000_0000, 32'sh0000_0000);
        load_point(4'd1, 32'sh0001_0000, 32'sh0002_0000);
        evaluate(32'sh0000_8000);
        evaluate(32'sh0000_0000);
        evaluate(32'sh0001_0000);
        evaluate(-32'sh0001_0000);
        evaluate(32'sh0003_0000);

        // A slope of one half in raw units gives exact halves, which must round
        // away from zero on both sides of the origin.
        load_point(4'd1, 32'sd2, 32'sd1);
        evaluate(32'sd1);
        evaluate(-32'sd1);

        // A very steep segment at the bottom of the range drives the result past
        // both 32-bit limits; a query on the first point gives its y exactly.
        load_point(4'd0, 32'sh8000_0000, 32'sh0000_0000);
        load_point(4'd1, 32'sh8000_0001, 32'sh7FFF_FFFF);
        evaluate(32'sh7FFF_FFFF);
        evaluate(32'sh8000_0000);
        load_point(4'd1, 32'sh8000_0001, 32'sh8000_0000);
        evaluate(32'sh7FFF_FFFF);

        // Both points on the same x: the result is the left y without saturation.
        load_point(4'd1, 32'sh8000_0000, 32'sh1234_5678);
        evaluate(32'sd5);

        // Points in falling order: the negative width is used as it stands.
        load_point(4'd0, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
        load_point(4'd1, 32'sh8000_0000, 32'sh7FFF_FFFF);
        evaluate(32'sh0000_0000);

        // Random phases. Each begins with a count write, the extremes and the
        // out-of-range values first, and then mostly loads a sorted table and
        // queries it; the rest scribbles over single slots or mixes loads of any
        // slot with queries.
        phase = 0;
        while (words_sent < TOTAL_WORDS)
        begin
            count_val = (phase < 6) ? fixed_counts[phase] : 5'($urandom_range(0, 31));
            write_count(count_val);
            n    = points_in_use(count_val);
            kind = $urandom_range(0, 9);
            if (kind < 7 || !slots_ready(n))
            begin
                load_sorted_table(n);
                repeat ($urandom_range(10, 40)) evaluate(pick_query(n));
            end
            else if (kind < 9)
            begin
                repeat (20)
                begin
                    if ($urandom_range(0, 2) == 0)
                        load_point(4'($urandom()), $urandom(), $urandom());
                    else if ($urandom_range(0, 1) == 0)
                        evaluate(pick_query(n));
                    else
                        evaluate($urandom());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    load_point(4'($urandom_range(0, n - 1)), $urandom(), $urandom());
                repeat (15) evaluate(pick_query(n));
            end
            phase++;
        end

        // Drain: every outstanding evaluate must come back, and nothing more may
        // arrive in the quiet period after it.
        in_valid <= 1'b0;
        while (curve.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES + 16) @(posedge clk);

        if (curve.errors == 0 && curve.awaited.size() == 0)
            $display("PASS piecewise_linear_interpolator");
        else
            $display("FAIL piecewise_linear_interpolator");
        $finish;
    end

endmodule

@@ filelist.f @@
src/pli_pkg.sv
src/pli_ram.sv
src/pli_ctrl.sv
src/pli_dp.sv
src/piecewise_linear_interpolator.sv
bench/tb_piecewise_linear_interpolator.sv
